// ===== hw/rtl/fpr_pkg.sv =====
// Shared constants, status codes and record types of the framed packet receiver.
package fpr_pkg;

    // Default frame store depth in bytes.
    localparam int BUF_LEN_DEFAULT = 64;
    // Header, type, code, two length bytes, checksum and end byte.
    localparam int FRAME_OVERHEAD  = 7;
    // Store entry of the first payload byte.
    localparam int PAYLOAD_BASE    = 5;
    // Width of the payload length carried with each result.
    localparam int LEN_W           = 6;
    // Depth of the command queue between the parser and the emitter.
    localparam int CMD_DEPTH       = 2;

    // Input word kinds.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Configuration register indexes; register i sits at byte address 4*i.
    typedef enum logic [1:0] {
        REG_HEADER  = 2'd0,
        REG_END     = 2'd1,
        REG_TIMEOUT = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_GOOD    = 3'd0,
        ST_LENGTH  = 3'd1,
        ST_END     = 3'd2,
        ST_SUM     = 3'd3,
        ST_TIMEOUT = 3'd4
    } status_t;

    // One finished frame or error, as handed from the parser to the emitter.
    typedef struct packed {
        status_t              status;
        logic [7:0]           frame_type;
        logic [7:0]           frame_code;
        logic [LEN_W-1:0]     length;
    } cmd_t;

    // Configuration register values.
    typedef struct packed {
        logic [7:0]  header_byte;
        logic [7:0]  end_byte;
        logic [15:0] timeout_ticks;
    } cfg_t;

    // One result word.
    typedef struct packed {
        status_t          status;
        logic [7:0]       frame_type;
        logic [7:0]       frame_code;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       payload_byte;
        logic             payload_valid;
        logic             last;
    } result_t;

endpackage

// ===== hw/rtl/fpr_item_if.sv =====
// Input channel: received bytes and timer ticks with a valid/ready handshake.
interface fpr_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, mode, rx_byte, input ready);
    modport sink   (input valid, mode, rx_byte, output ready);
endinterface

// ===== hw/rtl/fpr_result_if.sv =====
// Result channel: frame status and payload bytes with a valid/ready handshake.
interface fpr_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] frame_type;
    logic [7:0] frame_code;
    logic [5:0] payload_length;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       last;

    modport source (output valid, status, frame_type, frame_code, payload_length,
                    payload_byte, payload_valid, last, input ready);
    modport sink   (input valid, status, frame_type, frame_code, payload_length,
                    payload_byte, payload_valid, last, output ready);
endinterface

// ===== hw/rtl/fpr_front.sv =====
// Frame parser: hunts for the header, stores bytes, checks frames and queues outcomes.
module fpr_front #(
    parameter int BUF_LEN = fpr_pkg::BUF_LEN_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fpr_item_if.sink                    item,
    input  fpr_pkg::cfg_t               cfg,
    input  logic                        fifo_full,
    input  logic                        drained,
    output logic                        push,
    output fpr_pkg::cmd_t               cmd,
    output logic                        wr_en,
    output logic [$clog2(BUF_LEN)-1:0]  wr_addr,
    output logic [7:0]                  wr_data
);
    import fpr_pkg::*;

    localparam int          ADDR_W  = $clog2(BUF_LEN);
    localparam int          FILL_W  = $clog2(BUF_LEN + 1);
    localparam logic [15:0] MAX_LEN = 16'(BUF_LEN - FRAME_OVERHEAD);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       timer_reg, timer_next;
    logic [7:0]        sum_reg, sum_next;
    logic              busy_reg, busy_next;
    logic [7:0]        type_reg, type_next;
    logic [7:0]        code_reg, code_next;
    logic [7:0]        len_hi_reg, len_hi_next;
    logic [7:0]        len_lo_reg, len_lo_next;
    logic [7:0]        prev_reg, prev_next;

    logic              accept;
    logic [15:0]       frame_len;
    logic [15:0]       timer_dec;
    logic [7:0]        sum_excl;
    logic [FILL_W:0]   fill_inc;
    logic              do_store;
    logic              do_check;
    logic              drop;

    // New words are held off while a good frame is still being read out or the command queue is full.
    assign item.ready = !busy_reg && !fifo_full;
    assign accept     = item.valid && item.ready;

    assign frame_len  = {len_hi_reg, len_lo_reg};
    assign timer_dec  = (timer_reg == '0) ? '0 : timer_reg - 16'd1;
    // Sum of type, code, length and payload: everything before the checksum.
    assign sum_excl   = sum_reg - prev_reg;
    assign fill_inc   = {1'b0, fill_reg} + (FILL_W + 1)'(1);

    assign wr_addr    = fill_reg[ADDR_W-1:0];
    assign wr_data    = item.rx_byte;

    // Classify the accepted word and work out the frame state.
    always_comb
    begin
        fill_next   = fill_reg;
        timer_next  = timer_reg;
        sum_next    = sum_reg;
        busy_next   = busy_reg;
        type_next   = type_reg;
        code_next   = code_reg;
        len_hi_next = len_hi_reg;
        len_lo_next = len_lo_reg;
        prev_next   = prev_reg;
        push        = 1'b0;
        cmd         = '0;
        do_store    = 1'b0;
        do_check    = 1'b0;
        drop        = 1'b0;

        if (accept)
        begin
            if (item.mode == MODE_TICK)
            begin
                timer_next = timer_dec;
                if (fill_reg != '0 && timer_dec == '0)
                begin
                    push       = 1'b1;
                    cmd.status = ST_TIMEOUT;
                    drop       = 1'b1;
                end
            end
            else
            begin
                timer_next = cfg.timeout_ticks;
                priority if (fill_reg == '0)
                begin
                    do_store = (item.rx_byte == cfg.header_byte);
                end
                else if (fill_reg == FILL_W'(1))
                begin
                    do_store = (item.rx_byte != cfg.header_byte);
                end
                else
                begin
                    do_store = 1'b1;
                    do_check = (fill_reg >= FILL_W'(FRAME_OVERHEAD - 1));
                end
            end
        end

        // Store the byte and capture the fixed header fields.
        if (do_store)
        begin
            fill_next = fill_inc[FILL_W-1:0];
            prev_next = item.rx_byte;
            if (fill_reg != '0)
            begin
                sum_next = sum_reg + item.rx_byte;
            end
            if (fill_reg == FILL_W'(1))
            begin
                type_next = item.rx_byte;
            end
            if (fill_reg == FILL_W'(2))
            begin
                code_next = item.rx_byte;
            end
            if (fill_reg == FILL_W'(3))
            begin
                len_hi_next = item.rx_byte;
            end
            if (fill_reg == FILL_W'(4))
            begin
                len_lo_next = item.rx_byte;
            end
        end

        // Length bound first, then end byte and checksum once the frame is whole.
        if (do_check)
        begin
            if (frame_len > MAX_LEN)
            begin
                push       = 1'b1;
                cmd.status = ST_LENGTH;
                drop       = 1'b1;
            end
            else if (17'(fill_inc) == ({1'b0, frame_len} + 17'(FRAME_OVERHEAD)))
            begin
                push = 1'b1;
                drop = 1'b1;
                priority if (item.rx_byte != cfg.end_byte)
                begin
                    cmd.status = ST_END;
                end
                else if (prev_reg != sum_excl)
                begin
                    cmd.status = ST_SUM;
                end
                else
                begin
                    cmd.status     = ST_GOOD;
                    cmd.frame_type = type_reg;
                    cmd.frame_code = code_reg;
                    cmd.length     = frame_len[LEN_W-1:0];
                end
            end
        end

        if (drop)
        begin
            fill_next = '0;
            sum_next  = '0;
        end

        // The store stays locked from a good frame until the emitter has drained.
        if (drained)
        begin
            busy_next = 1'b0;
        end
        if (push && cmd.status == ST_GOOD)
        begin
            busy_next = 1'b1;
        end
    end

    assign wr_en = do_store;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            timer_reg <= '0;
            sum_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            timer_reg <= timer_next;
            sum_reg   <= sum_next;
            busy_reg  <= busy_next;
        end
    end

    // Captured header fields and the previous byte.
    always_ff @(posedge clk)
    begin
        type_reg   <= type_next;
        code_reg   <= code_next;
        len_hi_reg <= len_hi_next;
        len_lo_reg <= len_lo_next;
        prev_reg   <= prev_next;
    end

    // The store is never written while the emitter may still read it.
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !busy_reg)
        else $error("frame store written while a good frame is pending");

    // The fill count never runs past the store.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= FILL_W'(BUF_LEN))
        else $error("fill count beyond store depth");

endmodule

// ===== hw/rtl/fpr_cmd_fifo.sv =====
// Short command queue between the frame parser and the result emitter.
module fpr_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fpr_pkg::cmd_t  push_data,
    input  logic           pop,
    output fpr_pkg::cmd_t  pop_data,
    output logic           full,
    output logic           empty
);
    import fpr_pkg::*;

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             entry_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(CMD_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and count update with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue entries.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The parser only pushes when there is room.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("command pushed into a full queue");

endmodule

// ===== hw/rtl/fpr_store.sv =====
// Frame byte store: one write port from the parser, one registered read port.
module fpr_store #(
    parameter int BUF_LEN = fpr_pkg::BUF_LEN_DEFAULT
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(BUF_LEN)-1:0]  wr_addr,
    input  logic [7:0]                  wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(BUF_LEN)-1:0]  rd_addr,
    output logic [7:0]                  rd_data
);
    logic [7:0] mem_reg [BUF_LEN];
    logic [7:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, data valid the cycle after the request.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/fpr_back.sv =====
// Result emitter: turns queued outcomes into result words, reading payload bytes.
module fpr_back #(
    parameter int BUF_LEN = fpr_pkg::BUF_LEN_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fpr_pkg::cmd_t               cmd,
    input  logic                        empty,
    output logic                        pop,
    output logic                        rd_en,
    output logic [$clog2(BUF_LEN)-1:0]  rd_addr,
    input  logic [7:0]                  rd_data,
    output logic                        drained,
    fpr_result_if.source                result
);
    import fpr_pkg::*;

    localparam int ADDR_W = $clog2(BUF_LEN);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } back_state_t;

    back_state_t      state_reg, state_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    cmd_t             cur_reg, cur_next;
    result_t          out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             slot_free;
    logic [LEN_W-1:0] idx_inc;
    logic [LEN_W:0]   addr_wide;
    logic             final_byte;

    assign slot_free  = !out_valid_reg || result.ready;
    assign idx_inc    = idx_reg + LEN_W'(1);
    assign final_byte = (idx_inc == cur_reg.length);
    assign drained    = (state_reg == S_IDLE) && empty && !out_valid_reg;

    // Sequencing of error words and payload readout.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        pop            = 1'b0;
        rd_en          = 1'b0;
        addr_wide      = {1'b0, idx_reg} + (LEN_W + 1)'(PAYLOAD_BASE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty && slot_free)
                begin
                    pop      = 1'b1;
                    cur_next = cmd;
                    if (cmd.status != ST_GOOD || cmd.length == '0)
                    begin
                        // Errors and empty frames give a single word.
                        out_next            = '0;
                        out_next.status     = cmd.status;
                        out_next.last       = 1'b1;
                        if (cmd.status == ST_GOOD)
                        begin
                            out_next.frame_type = cmd.frame_type;
                            out_next.frame_code = cmd.frame_code;
                        end
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        addr_wide  = (LEN_W + 1)'(PAYLOAD_BASE);
                        rd_en      = 1'b1;
                        idx_next   = '0;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                if (slot_free)
                begin
                    out_next.status         = ST_GOOD;
                    out_next.frame_type     = cur_reg.frame_type;
                    out_next.frame_code     = cur_reg.frame_code;
                    out_next.payload_length = cur_reg.length;
                    out_next.payload_byte   = rd_data;
                    out_next.payload_valid  = 1'b1;
                    out_next.last           = final_byte;
                    out_valid_next          = 1'b1;
                    idx_next                = idx_inc;
                    if (final_byte)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        addr_wide = {1'b0, idx_inc} + (LEN_W + 1)'(PAYLOAD_BASE);
                        rd_en     = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = addr_wide[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Frame context and output word.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    // Output port.
    assign result.valid          = out_valid_reg;
    assign result.status         = out_reg.status;
    assign result.frame_type     = out_reg.frame_type;
    assign result.frame_code     = out_reg.frame_code;
    assign result.payload_length = out_reg.payload_length;
    assign result.payload_byte   = out_reg.payload_byte;
    assign result.payload_valid  = out_reg.payload_valid;
    assign result.last           = out_reg.last;

    // Readout index stays inside the frame's payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |-> idx_reg < cur_reg.length)
        else $error("payload readout ran past the frame length");

    // Only good frames carry payload bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.payload_valid |-> out_reg.status == ST_GOOD)
        else $error("payload byte on an error word");

endmodule

// ===== hw/rtl/framed_packet_receiver.sv =====
// Framed packet receiver top level: configuration registers, parser, queue, store, emitter.
// Each input word is taken on a valid/ready handshake; the next word can follow in the next cycle
// unless input is held off. An error word passes the command queue and the output register; a
// good frame's payload words pass the queue, the store read register and the output register,
// one per cycle while the result receiver is ready. Input is held off from a good frame's end
// until its payload has drained, since the store has a single write and a single read port.
// Reset clears control state and loads the registers with 170, 85 and 1000; the store is not cleared.
module framed_packet_receiver #(
    parameter int BUF_LEN = fpr_pkg::BUF_LEN_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    fpr_item_if.sink      item,
    fpr_result_if.source  result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import fpr_pkg::*;

    localparam int ADDR_W = $clog2(BUF_LEN);

    cfg_t              cfg_reg, cfg_next;
    logic              cfg_write;

    logic              push;
    cmd_t              push_cmd;
    cmd_t              pop_cmd;
    logic              pop;
    logic              fifo_full;
    logic              fifo_empty;
    logic              drained;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // Configuration port: no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_HEADER:  cfg_next.header_byte   = pwdata[7:0];
                REG_END:     cfg_next.end_byte      = pwdata[7:0];
                REG_TIMEOUT: cfg_next.timeout_ticks = pwdata[15:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_HEADER:  prdata = {24'b0, cfg_reg.header_byte};
            REG_END:     prdata = {24'b0, cfg_reg.end_byte};
            REG_TIMEOUT: prdata = {16'b0, cfg_reg.timeout_ticks};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte   <= 8'd170;
            cfg_reg.end_byte      <= 8'd85;
            cfg_reg.timeout_ticks <= 16'd1000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: parse and classify.
    fpr_front #(
        .BUF_LEN (BUF_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg_reg),
        .fifo_full (fifo_full),
        .drained   (drained),
        .push      (push),
        .cmd       (push_cmd),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Queue of outcomes.
    fpr_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    // Frame bytes.
    fpr_store #(
        .BUF_LEN (BUF_LEN)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Back: emit result words.
    fpr_back #(
        .BUF_LEN (BUF_LEN)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (pop_cmd),
        .empty   (fifo_empty),
        .pop     (pop),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .drained (drained),
        .result  (result)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the framed packet receiver: predicts every result word and compares.
`timescale 1ns / 100ps

module tb_top;
    import fpr_pkg::*;

    localparam int STORE_DEPTH   = BUF_LEN_DEFAULT;
    localparam int MAX_LENGTH    = STORE_DEPTH - FRAME_OVERHEAD;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int PHASE_WORDS   = 25;

    // Predicts the result words of the receiver and checks the observed ones.
    class frame_scoreboard;
        logic [7:0]  header_byte;
        logic [7:0]  end_byte;
        logic [15:0] timeout_ticks;
        logic [7:0]  frame_bytes[STORE_DEPTH];
        int          fill;
        logic [15:0] idle_timer;
        logic [7:0]  byte_sum;
        result_t     words_due[$];
        int          mismatches;

        function new();
            header_byte   = 8'd170;
            end_byte      = 8'd85;
            timeout_ticks = 16'd1000;
            fill          = 0;
            idle_timer    = '0;
            byte_sum      = '0;
            mismatches    = 0;
            foreach (frame_bytes[i])
                frame_bytes[i] = '0;
        endfunction

        function void set_config(cfg_reg_t idx, logic [31:0] value);
            case (idx)
                REG_HEADER:  header_byte   = value[7:0];
                REG_END:     end_byte      = value[7:0];
                REG_TIMEOUT: timeout_ticks = value[15:0];
                default: ;
            endcase
        endfunction

        function void push_word(status_t st, logic [7:0] ty, logic [7:0] cd, logic [5:0] ln,
                                logic [7:0] pb, logic pv, logic lst);
            result_t w;
            w.status         = st;
            w.frame_type     = ty;
            w.frame_code     = cd;
            w.payload_length = ln;
            w.payload_byte   = pb;
            w.payload_valid  = pv;
            w.last           = lst;
            words_due.push_back(w);
        endfunction

        // An error gives one bare word and the receiver hunts again.
        function void drop_with(status_t st);
            push_word(st, '0, '0, '0, '0, 1'b0, 1'b1);
            fill     = 0;
            byte_sum = '0;
        endfunction

        function void keep_byte(logic [7:0] b);
            if (fill < STORE_DEPTH)
            begin
                frame_bytes[fill] = b;
                if (fill != 0)
                    byte_sum = byte_sum + b;
                fill++;
            end
        endfunction

        // Length bound first, then end byte, then checksum, then the payload run.
        function void judge_frame();
            int         len;
            logic [7:0] sum;
            if (fill < FRAME_OVERHEAD)
                return;
            len = int'({frame_bytes[3], frame_bytes[4]});
            if (len > MAX_LENGTH)
            begin
                drop_with(ST_LENGTH);
                return;
            end
            if (fill < len + FRAME_OVERHEAD)
                return;
            if (frame_bytes[len + PAYLOAD_BASE + 1] != end_byte)
            begin
                drop_with(ST_END);
                return;
            end
            sum = byte_sum - frame_bytes[len + PAYLOAD_BASE] - frame_bytes[len + PAYLOAD_BASE + 1];
            if (frame_bytes[len + PAYLOAD_BASE] != sum)
            begin
                drop_with(ST_SUM);
                return;
            end
            if (len == 0)
                push_word(ST_GOOD, frame_bytes[1], frame_bytes[2], '0, '0, 1'b0, 1'b1);
            else
                for (int i = 0; i < len; i++)
                    push_word(ST_GOOD, frame_bytes[1], frame_bytes[2], 6'(len),
                              frame_bytes[PAYLOAD_BASE + i], 1'b1, (i + 1 == len));
            fill     = 0;
            byte_sum = '0;
        endfunction

        // Notes one accepted input word.
        function void take_rx_word(logic mode, logic [7:0] b);
            if (mode == MODE_TICK)
            begin
                if (idle_timer != 0)
                    idle_timer--;
                if (fill > 0 && idle_timer == 0)
                    drop_with(ST_TIMEOUT);
                return;
            end
            idle_timer = timeout_ticks;
            if (fill == 0)
            begin
                if (b == header_byte)
                    keep_byte(b);
            end
            else if (fill == 1)
            begin
                if (b != header_byte)
                    keep_byte(b);
            end
            else
            begin
                keep_byte(b);
                judge_frame();
            end
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] ERROR %s", $time, what);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        // Checks one accepted result word against the oldest prediction.
        task check_result(result_t got);
            result_t want;
            if (words_due.size() == 0)
            begin
                report($sformatf("result word with nothing predicted, status %0d", got.status));
                return;
            end
            want = words_due.pop_front();
            compare_field("status", 16'(got.status), 16'(want.status));
            compare_field("frame_type", 16'(got.frame_type), 16'(want.frame_type));
            compare_field("frame_code", 16'(got.frame_code), 16'(want.frame_code));
            compare_field("payload_length", 16'(got.payload_length),
                          16'(want.payload_length));
            compare_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
            compare_field("payload_valid", 16'(got.payload_valid), 16'(want.payload_valid));
            compare_field("last", 16'(got.last), 16'(want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fpr_item_if   item_bus();
    fpr_result_if result_bus();

    frame_scoreboard fsb;
    result_t         seen_word;
    int              cycle_count = 0;
    int              used_words = 0;
    int              sender_calm = 0;
    int              receiver_calm = 0;
    int              receiver_wait;
    bit              hold_request = 1'b0;

    framed_packet_receiver u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock, 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run length guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("framed_packet_receiver: mismatch");
            $finish;
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            seen_word.status         = status_t'(result_bus.status);
            seen_word.frame_type     = result_bus.frame_type;
            seen_word.frame_code     = result_bus.frame_code;
            seen_word.payload_length = result_bus.payload_length;
            seen_word.payload_byte   = result_bus.payload_byte;
            seen_word.payload_valid  = result_bus.payload_valid;
            seen_word.last           = result_bus.last;
            fsb.check_result(seen_word);
        end
    end

    // Wait before the next word: calm stretches of no waiting, else a random wait.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Result receiver; a requested hold keeps ready low for a long counted stretch.
    initial
    begin
        result_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                receiver_wait = HOLD_CYCLES;
                hold_request  = 1'b0;
            end
            else
                receiver_wait = draw_wait(receiver_calm);
            if (receiver_wait > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (receiver_wait) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge clk); while (!result_bus.valid);
        end
    end

    // Offers one input word and notes it once accepted.
    task automatic send_word(input logic mode, input logic [7:0] value);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.mode    <= mode;
        item_bus.rx_byte <= value;
        do @(posedge clk); while (!item_bus.ready);
        if (mode == MODE_BYTE && (fsb.fill != 0 || value == fsb.header_byte))
            used_words++;
        fsb.take_rx_word(mode, value);
    endtask

    // Stops offering and waits until every predicted word has arrived.
    task automatic settle();
        item_bus.valid <= 1'b0;
        while (fsb.words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        fsb.set_config(idx, value);
    endtask

    task automatic write_config(input logic [7:0] hdr, input logic [7:0] tail,
                                input logic [15:0] ticks);
        write_reg(REG_HEADER, 32'(hdr));
        write_reg(REG_END, 32'(tail));
        write_reg(REG_TIMEOUT, 32'(ticks));
    endtask

    // Sends one frame; a length over the bound stops two bytes after the length bytes,
    // where the length check fires.
    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fcode,
                              input logic [15:0] flen, input int repeats,
                              input logic [7:0] sum_error, input logic [7:0] closing);
        logic [7:0] sum;
        logic [7:0] data;
        sum = ftype + fcode + flen[15:8] + flen[7:0];
        send_word(MODE_BYTE, fsb.header_byte);
        repeat (repeats) send_word(MODE_BYTE, fsb.header_byte);
        send_word(MODE_BYTE, ftype);
        send_word(MODE_BYTE, fcode);
        send_word(MODE_BYTE, flen[15:8]);
        send_word(MODE_BYTE, flen[7:0]);
        if (flen > MAX_LENGTH)
        begin
            send_word(MODE_BYTE, 8'($urandom));
            send_word(MODE_BYTE, 8'($urandom));
            return;
        end
        for (int i = 0; i < flen; i++)
        begin
            data = 8'($urandom);
            sum  = sum + data;
            send_word(MODE_BYTE, data);
        end
        send_word(MODE_BYTE, sum + sum_error);
        send_word(MODE_BYTE, closing);
    endtask

    // Brings a stray partial frame back to hunting, by ticks or by filler bytes.
    task automatic resync();
        int tries;
        tries = 0;
        while (fsb.fill != 0 && tries < 80)
        begin
            if (fsb.timeout_ticks <= 16)
                send_word(MODE_TICK, 8'($urandom));
            else
                send_word(MODE_BYTE, ~fsb.header_byte);
            tries++;
        end
    endtask

    function automatic logic [7:0] pick_type();
        logic [7:0] t;
        t = 8'($urandom);
        if (t == fsb.header_byte)
            t = ~t;
        return t;
    endfunction

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 16'($urandom_range(0, 8));
        if (r < 95)
            return 16'($urandom_range(9, MAX_LENGTH - 1));
        return 16'(MAX_LENGTH);
    endfunction

    // Mostly well-formed frames with random content, the rest broken frames and noise.
    task automatic run_random(input int budget);
        int         start;
        int         pick;
        int         repeats;
        logic [7:0] ftype;
        start = used_words;
        while (used_words - start < budget)
        begin
            resync();
            pick    = $urandom_range(0, 99);
            ftype   = pick_type();
            repeats = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            if (pick < 66)
                send_frame(ftype, 8'($urandom), pick_length(), repeats, 8'd0, fsb.end_byte);
            else if (pick < 74)
                send_frame(ftype, 8'($urandom), pick_length(), repeats, 8'd0,
                           fsb.end_byte ^ 8'($urandom_range(1, 255)));
            else if (pick < 82)
                send_frame(ftype, 8'($urandom), pick_length(), repeats,
                           8'($urandom_range(1, 255)), fsb.end_byte);
            else if (pick < 88)
                send_frame(ftype, 8'($urandom), 16'($urandom_range(MAX_LENGTH + 1, 65535)),
                           repeats, 8'd0, fsb.end_byte);
            else if (pick < 94 && fsb.timeout_ticks <= 16)
            begin
                // Partial frame left to go stale.
                send_word(MODE_BYTE, fsb.header_byte);
                repeat ($urandom_range(0, 4)) send_word(MODE_BYTE, 8'($urandom));
                resync();
            end
            else
                repeat ($urandom_range(1, 4))
                    send_word(1'($urandom_range(0, 1)), 8'($urandom));
        end
    endtask

    // Stimulus.
    initial
    begin
        fsb = new();
        rst_n = 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        item_bus.valid   <= 1'b0;
        item_bus.mode    <= MODE_BYTE;
        item_bus.rx_byte <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases on the reset header and end bytes, with a one-tick timeout.
        write_reg(REG_TIMEOUT, 32'd1);
        send_word(MODE_TICK, 8'h00);
        send_word(MODE_BYTE, 8'h00);
        send_frame(8'hFF, 8'h00, 16'd0, 1, 8'd0, fsb.end_byte);
        send_frame(8'h01, 8'h02, 16'h003A, 0, 8'd0, fsb.end_byte);
        send_frame(8'h03, 8'h04, 16'd0, 0, 8'd0, 8'h00);
        send_frame(8'h05, 8'h06, 16'd0, 0, 8'h01, fsb.end_byte);
        send_word(MODE_BYTE, fsb.header_byte);
        send_word(MODE_TICK, 8'hFF);
        settle();

        // Long receiver hold while a full-size frame and a shorter frame are sent.
        write_config(8'h00, 8'hFF, 16'd0);
        hold_request = 1'b1;
        send_frame(pick_type(), 8'($urandom), 16'(MAX_LENGTH), 0, 8'd0, fsb.end_byte);
        send_frame(pick_type(), 8'($urandom), 16'($urandom_range(20, 40)), 0, 8'd0,
                   fsb.end_byte);
        settle();
        run_random(PHASE_WORDS);
        settle();

        write_config(8'hFF, 8'h00, 16'hFFFF);
        run_random(PHASE_WORDS);
        settle();

        write_config(8'($urandom), 8'($urandom), 16'd3);
        run_random(PHASE_WORDS);
        settle();

        write_config(8'd170, 8'd85, 16'($urandom_range(4, 12)));
        run_random(PHASE_WORDS);
        settle();

        if (fsb.mismatches == 0)
            $display("framed_packet_receiver: match");
        else
            $display("framed_packet_receiver: mismatch");
        $finish;
    end

endmodule
